// ----- rtl/core/grcpt_pkg.sv -----
`timescale 1ns / 1ps
package grcpt_pkg;

   // Default number of column cells
   localparam int MAX_WIDTH_DEF = 32;
   // Tallest glyph handled; taller settings clamp here
   localparam int MAX_HEIGHT = 32;

   localparam int CfgW = 6;
   localparam int IdxW = 3;

   // Register indexes of the configuration port
   localparam logic [IdxW-1:0] REG_GLYPH_WIDTH  = 3'd0;
   localparam logic [IdxW-1:0] REG_GLYPH_HEIGHT = 3'd1;
   localparam logic [IdxW-1:0] REG_BIT_REVERSE  = 3'd2;
   localparam logic [IdxW-1:0] REG_UNDERLINE_ON = 3'd3;
   localparam logic [IdxW-1:0] REG_INVERT_ON    = 3'd4;

   localparam logic [CfgW-1:0] WIDTH_RESET  = 6'd16;
   localparam logic [CfgW-1:0] HEIGHT_RESET = 6'd16;

   // Per-cycle control broadcast from the input side to the cells
   typedef struct packed {
      logic       wr;     // a glyph word is accepted
      logic       load;   // that word closes a page: hand accumulators to the shift chain
      logic [1:0] bir;    // byte position within the row
      logic [2:0] sub;    // row within the page
      logic [1:0] page;   // page of the closing word
      logic       gend;   // closing word ends the glyph
      logic [7:0] data;   // glyph word
   } grcpt_ctl_type;

endpackage

// ----- rtl/core/grcpt_cell.sv -----
`timescale 1ns / 1ps
module grcpt_cell
   import grcpt_pkg::*;
#(
   parameter int COL = 0,
   parameter int W_W = 6
) (
   input  logic          clock,
   input  logic          reset,
   input  grcpt_ctl_type ctl,
   input  logic          shift,
   input  logic [W_W-1:0] w_eff,
   input  logic [7:0]    sh_next,
   output logic [7:0]    sh_o
);

   localparam int  GRP    = COL / 8;
   localparam int  BITPOS = 7 - (COL % 8);
   localparam bit  GRP_OK = (GRP < 4);
   localparam logic [1:0] GRP_CODE = GRP_OK ? 2'(GRP) : 2'd0;

   logic [7:0] acc_ff, acc_in;
   logic [7:0] sh_ff, sh_in;
   logic       hit;
   logic [7:0] merged;

   // Pick this column's pixel out of the incoming word
   assign hit = ctl.wr && GRP_OK && (ctl.bir == GRP_CODE) && (W_W'(COL) < w_eff)
                && ctl.data[BITPOS];
   assign merged = acc_ff | (hit ? (8'h80 >> ctl.sub) : 8'h00);

   // Accumulate, clear on page hand-off
   always_comb begin
      acc_in = ctl.load ? 8'h00 : merged;
   end

   // Load the finished column, else move toward cell zero on each taken word
   always_comb begin
      sh_in = sh_ff;
      if (ctl.load) begin
         sh_in = merged;
      end else if (shift) begin
         sh_in = sh_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= 8'h00;
      end else begin
         acc_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      sh_ff <= sh_in;
   end

   assign sh_o = sh_ff;

endmodule

// ----- rtl/core/grcpt_in_ctrl.sv -----
`timescale 1ns / 1ps
module grcpt_in_ctrl
   import grcpt_pkg::*;
#(
   parameter int W_W = 6
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   input  logic [7:0]     glyph_byte,
   input  logic [W_W-1:0] w_eff,
   input  logic [5:0]     h_eff,
   input  logic           out_busy,
   output grcpt_ctl_type  ctl
);

   logic [1:0]   bir_ff, bir_in;
   logic [4:0]   row_ff, row_in;
   logic [W_W:0] w_plus;
   logic [W_W:0] bpr;
   logic         row_end;
   logic         glyph_end;
   logic         page_end;
   logic         accept;

   // Row and page boundaries follow from the counters and the clamped width and height
   assign w_plus    = {1'b0, w_eff} + (W_W+1)'(7);
   assign bpr       = w_plus >> 3;
   assign row_end   = ((W_W+1)'(bir_ff) + (W_W+1)'(1)) >= bpr;
   assign glyph_end = ({1'b0, row_ff} + 6'd1) >= h_eff;
   assign page_end  = row_end && ((row_ff[2:0] == 3'd7) || glyph_end);

   // Hold a page-closing word until the shift chain is empty
   assign req_tready = !(page_end && out_busy);
   assign accept     = req_tvalid && req_tready;

   // Advance byte and row counters
   always_comb begin
      bir_in = bir_ff;
      row_in = row_ff;
      if (accept) begin
         if (!row_end) begin
            bir_in = bir_ff + 2'd1;
         end else begin
            bir_in = 2'd0;
            row_in = glyph_end ? 5'd0 : row_ff + 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bir_ff <= 2'd0;
         row_ff <= 5'd0;
      end else begin
         bir_ff <= bir_in;
         row_ff <= row_in;
      end
   end

   always_comb begin
      ctl.wr   = accept;
      ctl.load = accept && page_end;
      ctl.bir  = bir_ff;
      ctl.sub  = row_ff[2:0];
      ctl.page = row_ff[4:3];
      ctl.gend = glyph_end;
      ctl.data = glyph_byte;
   end

endmodule

// ----- rtl/core/grcpt_out_ctrl.sv -----
`timescale 1ns / 1ps
module grcpt_out_ctrl
   import grcpt_pkg::*;
#(
   parameter int W_W = 6
) (
   input  logic           clock,
   input  logic           reset,
   input  grcpt_ctl_type  ctl,
   input  logic [W_W-1:0] w_eff,
   input  logic           bit_reverse,
   input  logic           underline_on,
   input  logic           invert_on,
   input  logic [7:0]     head_byte,
   output logic           shift,
   output logic           busy,
   output logic           rsp_tvalid,
   input  logic           rsp_tready,
   output logic [15:0]    rsp_tdata,
   output logic           rsp_tuser,
   output logic           rsp_tlast
);

   localparam int COL_W = (W_W > 1) ? W_W - 1 : 1;

   logic             valid_ff, valid_in;
   logic [W_W-1:0]   col_ff, col_in;
   logic [1:0]       page_ff, page_in;
   logic             gend_ff, gend_in;
   logic             last_col;
   logic [7:0]       v_rev, v_ul, v_out;

   function automatic logic [7:0] flip_bits(input logic [7:0] v);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) begin
         r[i] = v[7-i];
      end
      return r;
   endfunction

   assign last_col = (col_ff + W_W'(1)) == w_eff;
   assign shift    = valid_ff && rsp_tready;
   assign busy     = valid_ff;

   // Start a page run on load, advance the column on each taken word
   always_comb begin
      valid_in = valid_ff;
      col_in   = col_ff;
      page_in  = page_ff;
      gend_in  = gend_ff;
      if (ctl.load) begin
         valid_in = 1'b1;
         col_in   = '0;
         page_in  = ctl.page;
         gend_in  = ctl.gend;
      end else if (shift) begin
         if (last_col) begin
            valid_in = 1'b0;
         end else begin
            col_in = col_ff + W_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      col_ff  <= col_in;
      page_ff <= page_in;
      gend_ff <= gend_in;
   end

   // Apply reverse, underline, invert in that order
   assign v_rev = bit_reverse ? flip_bits(head_byte) : head_byte;
   assign v_ul  = (underline_on && gend_ff) ? (v_rev ^ 8'h80) : v_rev;
   assign v_out = invert_on ? ~v_ul : v_ul;

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {1'b0, page_ff, 5'(col_ff[COL_W-1:0]), v_out};
   assign rsp_tuser  = last_col;
   assign rsp_tlast  = last_col && gend_ff;

endmodule

// ----- rtl/core/glyph_row_to_column_page_transpose_top.sv -----
`timescale 1ns / 1ps
// Glyph row to column page transpose.
// req_ carries a 1-bit-per-pixel glyph one word per beat, row by row, MSB
// leftmost, each row padded to whole bytes. rsp_ returns one column word per
// column for every page of eight rows: the word of the page's closing row
// (or the glyph's last row) starts a run of glyph_width column words.
// csr_ writes the five settings: width, height, bit reverse, underline,
// invert; write them only while no glyph is in flight.
// The first column word of a page is valid in the cycle after the
// page-closing word is taken; the run then moves out one word per cycle
// while the receiver is ready, through a shift chain of column cells.
// Throughput: one input word per cycle; a page-closing word waits while the
// previous page is still in the shift chain. A stalled receiver freezes the
// chain and the shown word; input keeps filling the next page until its
// closing word.
// Reset: accumulators and counters clear, settings return to width 16,
// height 16, options off. No clearing pass is needed.
module glyph_row_to_column_page_transpose_top
   import grcpt_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   input  logic [7:0]      req_tdata,   // [7:0] glyph_byte
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   output logic [15:0]     rsp_tdata,   // [7:0] column_byte, [12:8] column_index,
                                        // [14:13] page_index, [15] zero
   output logic            rsp_tuser,   // [0] last_of_page
   output logic            rsp_tlast,   // last_of_glyph
   input  logic            csr_we,
   input  logic [IdxW-1:0] csr_index,
   input  logic [CfgW-1:0] csr_wdata
);

   localparam int W_W = $clog2(MAX_WIDTH + 1);

   logic [CfgW-1:0] width_ff;
   logic [CfgW-1:0] height_ff;
   logic            bit_reverse_ff;
   logic            underline_ff;
   logic            invert_ff;
   logic [W_W-1:0]  w_eff;
   logic [5:0]      h_eff;
   grcpt_ctl_type   ctl;
   logic            shift;
   logic            busy;
   logic [7:0]      sh [MAX_WIDTH+1];

   // Settings registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff       <= WIDTH_RESET;
         height_ff      <= HEIGHT_RESET;
         bit_reverse_ff <= 1'b0;
         underline_ff   <= 1'b0;
         invert_ff      <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_GLYPH_WIDTH:  width_ff       <= csr_wdata;
            REG_GLYPH_HEIGHT: height_ff      <= csr_wdata;
            REG_BIT_REVERSE:  bit_reverse_ff <= csr_wdata[0];
            REG_UNDERLINE_ON: underline_ff   <= csr_wdata[0];
            REG_INVERT_ON:    invert_ff      <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Clamp width and height to their working range
   always_comb begin
      if (width_ff == '0) begin
         w_eff = W_W'(1);
      end else if (int'(width_ff) > MAX_WIDTH) begin
         w_eff = W_W'(MAX_WIDTH);
      end else begin
         w_eff = W_W'(width_ff);
      end
      if (height_ff == '0) begin
         h_eff = 6'd1;
      end else if (int'(height_ff) > MAX_HEIGHT) begin
         h_eff = 6'(MAX_HEIGHT);
      end else begin
         h_eff = height_ff;
      end
   end

   grcpt_in_ctrl #(.W_W(W_W)) u_in_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .glyph_byte (req_tdata),
      .w_eff      (w_eff),
      .h_eff      (h_eff),
      .out_busy   (busy),
      .ctl        (ctl)
   );

   // Row of column cells; the chain drains toward cell zero
   assign sh[MAX_WIDTH] = 8'h00;

   for (genvar i = 0; i < MAX_WIDTH; i++) begin : g_cell
      grcpt_cell #(.COL(i), .W_W(W_W)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .ctl     (ctl),
         .shift   (shift),
         .w_eff   (w_eff),
         .sh_next (sh[i+1]),
         .sh_o    (sh[i])
      );
   end

   grcpt_out_ctrl #(.W_W(W_W)) u_out_ctrl (
      .clock        (clock),
      .reset        (reset),
      .ctl          (ctl),
      .w_eff        (w_eff),
      .bit_reverse  (bit_reverse_ff),
      .underline_on (underline_ff),
      .invert_on    (invert_ff),
      .head_byte    (sh[0]),
      .shift        (shift),
      .busy         (busy),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .rsp_tlast    (rsp_tlast)
   );

   // A page hands off only into an empty chain
   a_load_empty: assert property (@(posedge clock) disable iff (reset)
      ctl.load |-> !rsp_tvalid)
      else $error("page loaded while previous run still pending");

   // A loaded page shows column zero next
   a_load_start: assert property (@(posedge clock) disable iff (reset)
      ctl.load |=> (rsp_tvalid && (rsp_tdata[12:8] == 5'd0)))
      else $error("page run did not start at column zero");

   // End of glyph is always end of page
   a_glyph_page: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> rsp_tuser)
      else $error("last_of_glyph without last_of_page");

   // The run ends after its last column word is taken
   a_run_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tuser) |=> !rsp_tvalid)
      else $error("output still valid after last column word");

endmodule

// ----- tb/tb_glyph_row_to_column_page_transpose_top.sv -----
`timescale 1ns / 1ps
module tb_glyph_row_to_column_page_transpose_top
   import grcpt_pkg::*;
;

   localparam int GLYPH_MAX_W    = MAX_WIDTH_DEF;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLD_OFF_LEN   = 400;
   localparam int REPORT_LIMIT   = 10;

   // One column word as it leaves the block
   typedef struct packed {
      logic [7:0] column_byte;
      logic [4:0] column_index;
      logic [1:0] page_index;
      logic       last_of_page;
      logic       last_of_glyph;
   } column_word_type;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_tvalid = 1'b0;
   logic            req_tready;
   logic [7:0]      req_tdata = '0;    // [7:0] glyph_byte
   logic            rsp_tvalid;
   logic            rsp_tready = 1'b0;
   logic [15:0]     rsp_tdata;         // [7:0] column_byte, [12:8] column_index,
                                       // [14:13] page_index, [15] zero
   logic            rsp_tuser;         // [0] last_of_page
   logic            rsp_tlast;         // last_of_glyph
   logic            csr_we = 1'b0;
   logic [IdxW-1:0] csr_index = '0;
   logic [CfgW-1:0] csr_wdata = '0;

   glyph_row_to_column_page_transpose_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Shadow copy of the settings and the page accumulators
   logic [CfgW-1:0] fmt_width     = WIDTH_RESET;
   logic [CfgW-1:0] fmt_height    = HEIGHT_RESET;
   logic            fmt_reverse   = 1'b0;
   logic            fmt_underline = 1'b0;
   logic            fmt_invert    = 1'b0;
   logic [7:0]      col_acc [GLYPH_MAX_W];
   logic [4:0]      row_pos  = '0;
   logic [1:0]      byte_pos = '0;

   column_word_type expected_columns[$];
   column_word_type seen_col, want_col;

   int  mismatch_count  = 0;
   int  words_sent      = 0;
   int  columns_checked = 0;
   int  glyphs_closed   = 0;
   int  idle_cycles     = 0;
   int  rsp_hold_cycles = 0;
   int  hold_len, stall_len;
   bit  sender_gaps     = 1'b0;
   bit  receiver_stalls = 1'b0;

   initial begin
      for (int i = 0; i < GLYPH_MAX_W; i++) col_acc[i] = '0;
   end

   // Width and height outside 1..limit behave as the nearest bound
   function automatic int unsigned clamp_dim(input logic [CfgW-1:0] v, input int unsigned limit);
      if (v == 0) return 1;
      if (v > limit) return limit;
      return 32'(v);
   endfunction

   function automatic void apply_csr_write(input logic [IdxW-1:0] idx,
                                           input logic [CfgW-1:0] val);
      case (idx)
         REG_GLYPH_WIDTH:  fmt_width = val;
         REG_GLYPH_HEIGHT: fmt_height = val;
         REG_BIT_REVERSE:  fmt_reverse = val[0];
         REG_UNDERLINE_ON: fmt_underline = val[0];
         REG_INVERT_ON:    fmt_invert = val[0];
         default: ;
      endcase
   endfunction

   // Fold one glyph word into the accumulators; queue the page when it closes
   function automatic void predict_columns(input logic [7:0] glyph_byte);
      int unsigned     w, h, bpr, x;
      logic [2:0]      sub;
      logic            glyph_done;
      logic [7:0]      v, flipped;
      column_word_type col;
      w   = clamp_dim(fmt_width, GLYPH_MAX_W);
      h   = clamp_dim(fmt_height, MAX_HEIGHT);
      bpr = (w + 7) / 8;
      sub = row_pos[2:0];
      for (int b = 0; b < 8; b++) begin
         x = int'(byte_pos) * 8 + b;
         if (x < w && glyph_byte[7 - b]) col_acc[x] = col_acc[x] | (8'h80 >> sub);
      end
      // mid-row word: only advance the byte position
      if (int'(byte_pos) + 1 < bpr) begin
         byte_pos++;
         return;
      end
      byte_pos   = '0;
      glyph_done = (int'(row_pos) + 1 >= h);
      if (sub == 3'd7 || glyph_done) begin
         for (x = 0; x < w; x++) begin
            v = col_acc[x];
            if (fmt_reverse) begin
               for (int i = 0; i < 8; i++) flipped[i] = v[7 - i];
               v = flipped;
            end
            if (fmt_underline && glyph_done) v[7] = ~v[7];
            if (fmt_invert) v = ~v;
            col.column_byte   = v;
            col.column_index  = x[4:0];
            col.page_index    = row_pos[4:3];
            col.last_of_page  = (x + 1 == w);
            col.last_of_glyph = (x + 1 == w) && glyph_done;
            expected_columns.push_back(col);
         end
         for (int i = 0; i < GLYPH_MAX_W; i++) col_acc[i] = '0;
      end
      if (glyph_done) begin
         row_pos = '0;
         glyphs_closed++;
      end else begin
         row_pos++;
      end
   endfunction

   // Sample all handshakes at the rising edge: settings, then input, then check
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we) apply_csr_write(csr_index, csr_wdata);
         if (req_tvalid && req_tready) predict_columns(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            columns_checked++;
            seen_col.column_byte   = rsp_tdata[7:0];
            seen_col.column_index  = rsp_tdata[12:8];
            seen_col.page_index    = rsp_tdata[14:13];
            seen_col.last_of_page  = rsp_tuser;
            seen_col.last_of_glyph = rsp_tlast;
            if (expected_columns.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("%t: column word %h (user %b last %b) with none expected",
                           $realtime, rsp_tdata, rsp_tuser, rsp_tlast);
            end else begin
               want_col = expected_columns.pop_front();
               if (seen_col.column_byte !== want_col.column_byte ||
                   seen_col.column_index !== want_col.column_index ||
                   seen_col.page_index !== want_col.page_index ||
                   seen_col.last_of_page !== want_col.last_of_page ||
                   seen_col.last_of_glyph !== want_col.last_of_glyph ||
                   rsp_tdata[15] !== 1'b0) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT) begin
                     $display("%t: column word mismatch: expected byte %h col %0d page %0d lp %b lg %b",
                              $realtime, want_col.column_byte, want_col.column_index,
                              want_col.page_index, want_col.last_of_page,
                              want_col.last_of_glyph);
                     $display("   got byte %h col %0d page %0d lp %b lg %b pad %b",
                              seen_col.column_byte, seen_col.column_index,
                              seen_col.page_index, seen_col.last_of_page,
                              seen_col.last_of_glyph, rsp_tdata[15]);
                  end
               end
            end
         end
      end
   end

   // Receiver: long hold-off on request, random stall bursts, else always ready
   always begin
      @(negedge clock);
      if (rsp_hold_cycles > 0) begin
         hold_len        = rsp_hold_cycles;
         rsp_hold_cycles = 0;
         rsp_tready <= 1'b0;
         repeat (hold_len - 1) @(negedge clock);
      end else if (receiver_stalls && $urandom_range(0, 3) == 0) begin
         stall_len = $urandom_range(1, 11);
         rsp_tready <= 1'b0;
         repeat (stall_len - 1) @(negedge clock);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Watchdog: end the run when nothing moves for too long
   initial begin
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("tb_glyph_row_to_column_page_transpose_top: done, errors");
      $finish;
   end

   // Offer one glyph word, with an optional gap first; returns at a falling edge
   task automatic send_glyph_word(input logic [7:0] glyph_byte);
      if (sender_gaps && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         req_tdata  <= 8'($urandom_range(0, 255));
         repeat ($urandom_range(1, 11)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= glyph_byte;
      do @(posedge clock); while (!(req_tvalid && req_tready));
      words_sent++;
      @(negedge clock);
   endtask

   // Stop offering, let every queued column word come back, then settle
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_columns.size() != 0) @(posedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input logic [IdxW-1:0] idx, input logic [CfgW-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_glyph_format(input logic [CfgW-1:0] w, input logic [CfgW-1:0] h,
                                   input logic [CfgW-1:0] rev, input logic [CfgW-1:0] ul,
                                   input logic [CfgW-1:0] inv);
      write_reg(REG_GLYPH_WIDTH, w);
      write_reg(REG_GLYPH_HEIGHT, h);
      write_reg(REG_BIT_REVERSE, rev);
      write_reg(REG_UNDERLINE_ON, ul);
      write_reg(REG_INVERT_ON, inv);
   endtask

   // Reset size, then shrink width and height with the counters past the new bounds
   task automatic test_reset_then_midglyph_change();
      send_glyph_word(8'hFF);
      send_glyph_word(8'h81);
      send_glyph_word(8'h3C);
      wait_drained();
      write_reg(REG_GLYPH_WIDTH, 6'd8);
      write_reg(REG_GLYPH_HEIGHT, 6'd1);
      send_glyph_word(8'hC3);
      wait_drained();
   endtask

   // Zero sizes act as 1x1; all options together; writes to unused indexes do nothing
   task automatic test_clamped_sizes_and_options();
      set_glyph_format(6'd0, 6'd0, 6'h3F, 6'h01, 6'h21);
      for (int i = REG_INVERT_ON + 1; i < (1 << IdxW); i++)
         write_reg(i[IdxW-1:0], 6'h02);
      send_glyph_word(8'hFF);
      send_glyph_word(8'h00);
      send_glyph_word(8'h7F);
      wait_drained();
   endtask

   // Height not a multiple of eight: short last page carries the underline
   task automatic test_partial_last_page();
      set_glyph_format(6'd3, 6'd9, 6'd0, 6'd1, 6'd0);
      send_glyph_word(8'hFF);
      send_glyph_word(8'h1F);
      send_glyph_word(8'hA0);
      repeat (6) send_glyph_word(8'($urandom_range(0, 255)));
      wait_drained();
   endtask

   // Receiver holds off while a wide, tall glyph streams in and fills the block
   task automatic test_receiver_holdoff();
      sender_gaps = 1'b0;
      set_glyph_format(6'h3F, 6'd26, 6'd0, 6'd1, 6'd0);
      rsp_hold_cycles = HOLD_OFF_LEN;
      repeat (4 * 26) send_glyph_word(8'($urandom_range(0, 255)));
      wait_drained();
   endtask

   // Random glyph formats with random pixels; now and then a glyph is cut short
   task automatic test_random_glyphs(input int budget, input bit with_idling);
      logic [CfgW-1:0] w, h, rev, ul, inv;
      int unsigned     words;
      int              sent;
      sender_gaps     = with_idling;
      receiver_stalls = with_idling;
      sent            = 0;
      while (sent < budget) begin
         case ($urandom_range(0, 7))
            0:       w = 6'($urandom_range(17, 32));
            1:       w = $urandom_range(0, 1) ? 6'd0 : 6'($urandom_range(33, 63));
            default: w = 6'($urandom_range(1, 16));
         endcase
         case ($urandom_range(0, 7))
            0:       h = 6'($urandom_range(13, 32));
            1:       h = $urandom_range(0, 1) ? 6'd0 : 6'($urandom_range(33, 63));
            default: h = 6'($urandom_range(1, 12));
         endcase
         rev    = 6'($urandom_range(0, 63));
         ul     = 6'($urandom_range(0, 63));
         inv    = 6'($urandom_range(0, 63));
         wait_drained();
         set_glyph_format(w, h, rev, ul, inv);
         words = ((clamp_dim(w, GLYPH_MAX_W) + 7) / 8) * clamp_dim(h, MAX_HEIGHT);
         if ($urandom_range(0, 7) == 0) words = $urandom_range(1, words);
         // keep the total on budget; the last glyph may be cut short
         if (words > unsigned'(budget - sent)) words = unsigned'(budget - sent);
         repeat (words) begin
            send_glyph_word(8'($urandom_range(0, 255)));
            sent++;
         end
      end
      wait_drained();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      sender_gaps     = 1'b1;
      receiver_stalls = 1'b1;
      test_reset_then_midglyph_change();
      test_clamped_sizes_and_options();
      test_partial_last_page();
      test_receiver_holdoff();
      test_random_glyphs(60, 1'b1);
      test_random_glyphs(30, 1'b0);

      repeat (8) @(posedge clock);
      if (expected_columns.size() != 0) begin
         mismatch_count += expected_columns.size();
         $display("%0d expected column words never arrived", expected_columns.size());
      end
      $display("run covered %0d glyph words in, %0d column words checked, %0d glyphs closed",
               words_sent, columns_checked, glyphs_closed);
      $display("  sizes 1x1 to 32x32 with clamped settings, option mixes, mid-glyph resizing");
      if (mismatch_count == 0) begin
         $display("tb_glyph_row_to_column_page_transpose_top: done, clean");
      end else begin
         $display("tb_glyph_row_to_column_page_transpose_top: done, errors");
      end
      $finish;
   end

endmodule
